@@ rtl/core/vfts_pkg.sv @@
`timescale 1ns / 1ps
package vfts_pkg;

    localparam int POS_BITS = 16;
    localparam int CFG_W    = 5;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IW-1:0] REG_COMPS  = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WR    = 6'b000010,
        S_MOD   = 6'b000100,
        S_CRD   = 6'b001000,
        S_RD    = 6'b010000,
        S_BLEND = 6'b100000
    } t_state;

endpackage

@@ rtl/core/vfts_blend.sv @@
`timescale 1ns / 1ps
module vfts_blend #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic signed [VALUE_BITS-1:0] i_v1,
    input  logic signed [VALUE_BITS-1:0] i_v2,
    input  logic signed [FRAC_BITS:0]    i_f,
    output logic signed [VALUE_BITS-1:0] o_r
);
    localparam int NW = VALUE_BITS + FRAC_BITS + 3;
    localparam int QW = NW - FRAC_BITS;

    logic signed [VALUE_BITS:0] diff;
    logic signed [NW-1:0]       prod;
    logic signed [NW-1:0]       num;
    logic signed [NW-1:0]       biased;
    logic signed [QW-1:0]       quo;
    logic signed [QW-1:0]       vmax;
    logic signed [QW-1:0]       vmin;

    always_comb begin
        diff   = (VALUE_BITS+1)'(i_v2) - (VALUE_BITS+1)'(i_v1);
        prod   = NW'(diff) * NW'(i_f);
        num    = (NW'(i_v1) <<< FRAC_BITS) + prod;
        // truncate toward zero
        biased = num + (num[NW-1] ? NW'((1 << FRAC_BITS) - 1) : NW'(0));
        quo    = QW'(biased >>> FRAC_BITS);
        vmax   = QW'({1'b0, {(VALUE_BITS-1){1'b1}}});
        vmin   = -vmax - QW'(1);
        if (quo > vmax) begin
            o_r = vmax[VALUE_BITS-1:0];
        end else if (quo < vmin) begin
            o_r = vmin[VALUE_BITS-1:0];
        end else begin
            o_r = quo[VALUE_BITS-1:0];
        end
    end
endmodule

@@ rtl/core/vector_field_trilinear_sampler.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake                   | payload
// in      | request   | i_in_valid / o_in_stall     | i_kind i_wrap_mode i_pos_* i_val_*
// out     | result    | o_out_valid / i_out_stall   | o_out_a o_out_b o_out_c
// cfg     | write     | i_cfg_we                    | i_cfg_idx i_cfg_data
// a write passes through the write state; a sample passes through acceptance, the remainder
// steps (run in both modes), coordinate mapping, reads on the single read port of the cell
// store and the steps of the shared blend units.
// synchronous active-low reset clears control and sets registers to 16,16,16,3.
// a finished result waits in the output register; the next request is taken meanwhile.
// a new result holds at the last blend step while the previous one is still stalled.
module vector_field_trilinear_sampler
    import vfts_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IW-1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_kind,
    input  logic                         i_wrap_mode,
    input  logic signed [POS_BITS-1:0]   i_pos_x,
    input  logic signed [POS_BITS-1:0]   i_pos_y,
    input  logic signed [POS_BITS-1:0]   i_pos_z,
    input  logic signed [VALUE_BITS-1:0] i_val_a,
    input  logic signed [VALUE_BITS-1:0] i_val_b,
    input  logic signed [VALUE_BITS-1:0] i_val_c,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [VALUE_BITS-1:0] o_out_a,
    output logic signed [VALUE_BITS-1:0] o_out_b,
    output logic signed [VALUE_BITS-1:0] o_out_c
);
    localparam int IP_BITS  = POS_BITS - FRAC_BITS;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int CW       = $clog2(MAX_DIM);
    localparam int DEPTH    = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW       = $clog2(DEPTH);
    localparam int SW       = AW + 2 * DIM_W;
    localparam int EW       = ((IP_BITS > DIM_W) ? IP_BITS : DIM_W) + 3;
    localparam int RST_SIZE = (16 > MAX_DIM) ? MAX_DIM : 16;

    // configuration
    logic [DIM_W-1:0]   r_size [3];
    logic [2*DIM_W-1:0] r_sxy;
    logic [1:0]         r_comps;
    logic [DIM_W-1:0]   cfg_size;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = DIM_W'(1);
        end else if (int'(i_cfg_data) > MAX_DIM) begin
            cfg_size = DIM_W'(MAX_DIM);
        end else begin
            cfg_size = DIM_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sxy <= (2*DIM_W)'(r_size[0]) * (2*DIM_W)'(r_size[1]);
        if (!i_rst_n) begin
            r_size[0] <= DIM_W'(RST_SIZE);
            r_size[1] <= DIM_W'(RST_SIZE);
            r_size[2] <= DIM_W'(RST_SIZE);
            r_comps   <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_X: r_size[0] <= cfg_size;
                REG_SIZE_Y: r_size[1] <= cfg_size;
                REG_SIZE_Z: r_size[2] <= cfg_size;
                REG_COMPS:  r_comps   <= (i_cfg_data[1:0] == 2'd0) ? 2'd1 : i_cfg_data[1:0];
                default:    r_comps   <= r_comps;
            endcase
        end
    end

    // request capture
    t_state r_state;
    logic [3:0] r_cnt;
    logic r_wrap;
    logic signed [IP_BITS-1:0]   r_ip [3];
    logic signed [FRAC_BITS:0]   r_fr [3];
    logic [IP_BITS-1:0]          r_mag [3];
    logic [DIM_W-1:0]            r_rem [3];
    logic [CW-1:0]               r_c0 [3];
    logic [CW-1:0]               r_c1 [3];
    logic signed [VALUE_BITS-1:0] r_val_a, r_val_b, r_val_c;

    logic signed [POS_BITS-1:0]  pos [3];
    logic signed [IP_BITS-1:0]   ip_n [3];
    logic signed [FRAC_BITS:0]   fr_n [3];
    logic in_acc;

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ip_n[k] = IP_BITS'((pos[k] + (pos[k][POS_BITS-1]
                      ? POS_BITS'((1 << FRAC_BITS) - 1) : POS_BITS'(0))) >>> FRAC_BITS);
            fr_n[k] = (FRAC_BITS+1)'(pos[k] - (POS_BITS'(ip_n[k]) <<< FRAC_BITS));
        end
    end

    // remainder step and coordinate mapping per axis
    logic [DIM_W:0]      rem_t [3];
    logic [DIM_W-1:0]    rem_n [3];
    logic signed [EW-1:0] ip_e [3];
    logic signed [EW-1:0] s_e [3];
    logic [DIM_W-1:0]    wr0 [3];
    logic [DIM_W-1:0]    m0 [3];
    logic [DIM_W-1:0]    m1 [3];
    logic                in_rng [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_t[k] = {r_rem[k], r_mag[k][IP_BITS-1]};
            if (rem_t[k] >= (DIM_W+1)'(r_size[k])) begin
                rem_n[k] = DIM_W'(rem_t[k] - (DIM_W+1)'(r_size[k]));
            end else begin
                rem_n[k] = DIM_W'(rem_t[k]);
            end
            ip_e[k] = EW'(r_ip[k]);
            s_e[k]  = $signed(EW'(r_size[k]));
            in_rng[k] = (ip_e[k] >= 0) && (ip_e[k] < s_e[k]);
            wr0[k] = (r_ip[k][IP_BITS-1] && r_rem[k] != '0) ? r_size[k] - r_rem[k] : r_rem[k];
            if (r_wrap) begin
                m0[k] = wr0[k];
                m1[k] = (wr0[k] == r_size[k] - DIM_W'(1)) ? '0 : wr0[k] + DIM_W'(1);
            end else begin
                if (ip_e[k] < 0) begin
                    m0[k] = '0;
                end else if (ip_e[k] >= s_e[k]) begin
                    m0[k] = r_size[k] - DIM_W'(1);
                end else begin
                    m0[k] = DIM_W'(ip_e[k]);
                end
                if (ip_e[k] + EW'(1) < 0) begin
                    m1[k] = '0;
                end else if (ip_e[k] + EW'(1) >= s_e[k]) begin
                    m1[k] = r_size[k] - DIM_W'(1);
                end else begin
                    m1[k] = DIM_W'(ip_e[k] + EW'(1));
                end
            end
        end
    end

    // cell store
    logic signed [VALUE_BITS-1:0] mem_a [DEPTH];
    logic signed [VALUE_BITS-1:0] mem_b [DEPTH];
    logic signed [VALUE_BITS-1:0] mem_c [DEPTH];
    logic signed [VALUE_BITS-1:0] r_q_a, r_q_b, r_q_c;
    logic [AW-1:0] addr;
    logic [CW-1:0] ax, ay, az;
    logic          wr_en;

    always_comb begin
        if (r_state == S_WR) begin
            ax = CW'(r_ip[0]);
            ay = CW'(r_ip[1]);
            az = CW'(r_ip[2]);
        end else begin
            ax = r_cnt[2] ? r_c1[0] : r_c0[0];
            ay = r_cnt[1] ? r_c1[1] : r_c0[1];
            az = r_cnt[0] ? r_c1[2] : r_c0[2];
        end
        addr  = AW'(SW'(ax) + SW'(ay) * SW'(r_size[0]) + SW'(az) * SW'(r_sxy));
        wr_en = (r_state == S_WR) && in_rng[0] && in_rng[1] && in_rng[2];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[addr] <= r_val_a;
        end
        r_q_a <= mem_a[addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_comps >= 2'd2) begin
            mem_b[addr] <= r_val_b;
        end
        r_q_b <= mem_b[addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_comps == 2'd3) begin
            mem_c[addr] <= r_val_c;
        end
        r_q_c <= mem_c[addr];
    end

    // corners and blend chain
    logic signed [VALUE_BITS-1:0] r_cor_a [8];
    logic signed [VALUE_BITS-1:0] r_cor_b [8];
    logic signed [VALUE_BITS-1:0] r_cor_c [8];
    logic signed [VALUE_BITS-1:0] op1_a, op2_a, op1_b, op2_b, op1_c, op2_c;
    logic signed [VALUE_BITS-1:0] bl_a, bl_b, bl_c;
    logic signed [FRAC_BITS:0]    bl_f;
    logic [2:0] lo_i, hi_i, dst_i;

    always_comb begin
        case (r_cnt)
            4'd0, 4'd1, 4'd2, 4'd3: begin
                lo_i  = {r_cnt[1:0], 1'b0};
                hi_i  = {r_cnt[1:0], 1'b1};
                dst_i = r_cnt[2:0];
                bl_f  = r_fr[2];
            end
            4'd4: begin
                lo_i = 3'd0; hi_i = 3'd1; dst_i = 3'd0; bl_f = r_fr[1];
            end
            4'd5: begin
                lo_i = 3'd2; hi_i = 3'd3; dst_i = 3'd1; bl_f = r_fr[1];
            end
            default: begin
                lo_i = 3'd0; hi_i = 3'd1; dst_i = 3'd0; bl_f = r_fr[0];
            end
        endcase
        op1_a = r_cor_a[lo_i]; op2_a = r_cor_a[hi_i];
        op1_b = r_cor_b[lo_i]; op2_b = r_cor_b[hi_i];
        op1_c = r_cor_c[lo_i]; op2_c = r_cor_c[hi_i];
    end

    vfts_blend #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_a (
        .i_v1(op1_a), .i_v2(op2_a), .i_f(bl_f), .o_r(bl_a));
    vfts_blend #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_b (
        .i_v1(op1_b), .i_v2(op2_b), .i_f(bl_f), .o_r(bl_b));
    vfts_blend #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_c (
        .i_v1(op1_c), .i_v2(op2_c), .i_f(bl_f), .o_r(bl_c));

    // sequencer
    logic r_ov;
    logic signed [VALUE_BITS-1:0] r_out_a, r_out_b, r_out_c;
    logic res_done;

    assign res_done = (r_state == S_BLEND) && (r_cnt == 4'd6);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wrap  <= i_wrap_mode;
            r_val_a <= i_val_a;
            r_val_b <= i_val_b;
            r_val_c <= i_val_c;
            for (int k = 0; k < 3; k++) begin
                r_ip[k]  <= ip_n[k];
                r_fr[k]  <= fr_n[k];
                r_mag[k] <= ip_n[k][IP_BITS-1] ? IP_BITS'(-ip_n[k]) : IP_BITS'(ip_n[k]);
                r_rem[k] <= '0;
            end
        end else if (r_state == S_MOD) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= rem_n[k];
                r_mag[k] <= r_mag[k] << 1;
            end
        end
        if (r_state == S_CRD) begin
            for (int k = 0; k < 3; k++) begin
                r_c0[k] <= CW'(m0[k]);
                r_c1[k] <= CW'(m1[k]);
            end
        end
        if (r_state == S_RD && r_cnt != 4'd0) begin
            r_cor_a[3'(r_cnt - 4'd1)] <= r_q_a;
            r_cor_b[3'(r_cnt - 4'd1)] <= r_q_b;
            r_cor_c[3'(r_cnt - 4'd1)] <= r_q_c;
        end else if (r_state == S_BLEND && r_cnt != 4'd6) begin
            // the last step keeps its operands while the result waits
            r_cor_a[dst_i] <= bl_a;
            r_cor_b[dst_i] <= bl_b;
            r_cor_c[dst_i] <= bl_c;
        end
        if (res_done && (!r_ov || !i_out_stall)) begin
            r_out_a <= bl_a;
            r_out_b <= (r_comps >= 2'd2) ? bl_b : '0;
            r_out_c <= (r_comps == 2'd3) ? bl_c : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (res_done && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        r_state <= i_kind ? S_MOD : S_WR;
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_MOD: begin
                    if (r_cnt == 4'(IP_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_CRD;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_CRD: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    // last corner lands in the cycle after its read
                    if (r_cnt == 4'd8) begin
                        r_cnt   <= '0;
                        r_state <= S_BLEND;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_BLEND: begin
                    if (r_cnt == 4'd6) begin
                        if (!r_ov || !i_out_stall) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_out_c     = r_out_c;

endmodule
